[design/olst_pkg.sv]
package olst_pkg;

    localparam int DATA_W     = 32;
    localparam int POS_W      = 4;
    localparam int OUT_CNT_W  = 5;
    localparam int CAPACITY_D = 16;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

    typedef struct packed {
        t_opcode                   opcode;
        logic signed [DATA_W-1:0]  item_value;
        logic [POS_W-1:0]          position;
    } t_in_word;

    typedef struct packed {
        logic                      ok;
        logic signed [DATA_W-1:0]  read_value;
        logic [OUT_CNT_W-1:0]      entry_count;
    } t_out_word;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                      capture;
        logic                      apply;
        t_opcode                   opcode;
        logic signed [DATA_W-1:0]  value;
    } t_cell_ctl;

endpackage

[design/olst_cell.sv]
module olst_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                              i_clk,
    input  olst_pkg::t_cell_ctl               i_ctl,
    input  logic [CW-1:0]                     i_count,
    input  logic signed [olst_pkg::DATA_W-1:0] i_next_data,
    input  logic                              i_hit,
    output logic                              o_hit,
    output logic signed [olst_pkg::DATA_W-1:0] o_data
);
    import olst_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     r_match;
    logic                     n_match;

    // Hit means a match sits at this index or below: take the neighbor's entry.
    assign o_hit  = i_hit | r_match;
    assign o_data = r_data;

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        if (i_ctl.capture) begin
            n_match = (r_data == i_ctl.value) && (IDX_C < i_count);
        end
        if (i_ctl.apply) begin
            case (i_ctl.opcode)
                OP_APPEND: begin
                    if (IDX_C == i_count) begin
                        n_data = i_ctl.value;
                    end
                end
                OP_REMOVE: begin
                    if (o_hit) begin
                        n_data = i_next_data;
                    end
                end
                default: begin
                    n_data = r_data;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

endmodule

[design/ordered_list_engine.sv]
// Channel   Ports                    Handshake
// command   start, i_word             taken when start is high and busy is low
// result    o_strobe, o_result       one word per command, valid for one cycle
//
// Each command is handled in turn: the accept edge latches it and has every cell
// compare its entry, the apply state then shifts or writes the chain of cells.
// The result strobes in the cycle after that, when a new command may already
// be taken; no command is taken while busy is high in the apply state.
// Reset empties the list at once; entries hold no reset value.
// The receiver cannot stall: a result is shown for exactly one cycle.
module ordered_list_engine #(
    parameter int CAPACITY = olst_pkg::CAPACITY_D
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  olst_pkg::t_in_word   i_word,
    output logic                 busy,
    output logic                 o_strobe,
    output olst_pkg::t_out_word  o_result
);
    import olst_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int RD_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    t_opcode                  r_op;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_rd_val;
    logic                     r_rd_ok;
    logic                     r_strobe;
    logic                     n_strobe;
    t_out_word                r_result;
    t_out_word                n_result;
    logic                     accept;
    logic                     apply;
    logic signed [DATA_W-1:0] rd_mux;
    logic                     rd_ok;
    logic [CW+OUT_CNT_W-1:0]  cnt_ext;
    t_cell_ctl                ctl;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic                     cell_hit  [CAPACITY+1];

    assign busy   = (r_state == ST_APPLY);
    assign accept = start && !busy;
    assign apply  = (r_state == ST_APPLY);

    assign ctl.capture = accept;
    assign ctl.apply   = apply;
    assign ctl.opcode  = r_op;
    assign ctl.value   = accept ? i_word.item_value : r_val;

    assign cell_hit[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] next_data;
        if (g == CAPACITY - 1) begin : g_last
            assign next_data = cell_data[g];
        end else begin : g_mid
            assign next_data = cell_data[g+1];
        end
        olst_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_count     (r_count),
            .i_next_data (next_data),
            .i_hit       (cell_hit[g]),
            .o_hit       (cell_hit[g+1]),
            .o_data      (cell_data[g])
        );
    end

    // Only the cells below 2**POS_W are reachable by a position.
    always_comb begin
        rd_mux = '0;
        for (int k = 0; k < RD_N; k++) begin
            if (i_word.position == POS_W'(k)) begin
                rd_mux = cell_data[k];
            end
        end
        rd_ok = ({{CW{1'b0}}, i_word.position} < {{POS_W{1'b0}}, r_count});
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_strobe = 1'b0;
        n_result = r_result;
        cnt_ext  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                n_state             = ST_IDLE;
                n_strobe            = 1'b1;
                n_result.ok         = 1'b0;
                n_result.read_value = '0;
                case (r_op)
                    OP_APPEND: begin
                        if (r_count < CAP_C) begin
                            n_result.ok = 1'b1;
                            n_count     = r_count + CW'(1);
                        end
                    end
                    OP_REMOVE: begin
                        if (cell_hit[CAPACITY]) begin
                            n_result.ok = 1'b1;
                            n_count     = r_count - CW'(1);
                        end
                    end
                    OP_READ: begin
                        if (r_rd_ok) begin
                            n_result.ok         = 1'b1;
                            n_result.read_value = r_rd_val;
                        end
                    end
                    default: begin
                        n_result.ok = 1'b0;
                    end
                endcase
                cnt_ext              = {{OUT_CNT_W{1'b0}}, n_count};
                n_result.entry_count = cnt_ext[OUT_CNT_W-1:0];
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Hold the command word for the apply cycle.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (accept) begin
            r_op     <= i_word.opcode;
            r_val    <= i_word.item_value;
            r_rd_val <= rd_mux;
            r_rd_ok  <= rd_ok;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
